// File: rtl/ectt_pkg.sv
`default_nettype none

package ectt_pkg;

  // Kind of an input item, carried on tuser.
  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpRead  = 2'd1,
    OpWrite = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StTick,
    StMod,
    StDiv,
    StDone
  } state_e;

  localparam logic [4:0] AddrStatus = 5'h00;
  localparam logic [4:0] AddrEnable = 5'h01;

  localparam int unsigned DividendW = 33;
  localparam int unsigned DivisorW  = 32;

  typedef struct packed {
    logic                 start;
    logic [DividendW-1:0] dividend;
    logic [DivisorW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DividendW-1:0] quotient;
    logic [DivisorW-1:0]  remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/eight_channel_tempo_timer.sv
`default_nettype none

// Channel  Direction  tdata                                   tuser
// s_axis   in         [7:0] address, [15:8] write_data,        [1:0] op
//                     [31:16] cycles
// m_axis   out        [7:0] read_data, [8] irq,                none
//                     [16:9] pending, [23:17] zero
//
// One item is worked on at a time; the result waits in an output register.
// A read, a status or enable write, or an unknown op goes from StExec to StDone.
// A tempo write waits in StDiv while a 33-step serial divider works out the interval.
// A tick visits the timers one at a time in StTick; an enabled timer whose counter
// reaches its interval waits in StMod while the same divider reduces that counter.
// Reset is asynchronous; a full output register holds StDone and stops new input.
module eight_channel_tempo_timer #(
  parameter int unsigned CLOCK_HZ   = 8000000,
  parameter int unsigned NUM_TIMERS = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // address, write_data, cycles
  input  wire  [1:0]  s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata    // read_data, irq, pending
);
  import ectt_pkg::*;

  localparam int unsigned IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_TIMERS - 1);
  localparam logic [3:0] NumTimersW = 4'(NUM_TIMERS);
  localparam logic [63:0] TicksPerMinL = 64'd60 * 64'(CLOCK_HZ);
  localparam logic [31:0] TicksPerMin = TicksPerMinL[31:0];

  state_e state_q, state_d;

  op_e         op_q;
  logic [4:0]  addr_q;
  logic [7:0]  data_q;
  logic [15:0] cycles_q;

  logic [IdxW-1:0]       idx_q, idx_d;
  logic [7:0]            rd_q, rd_d;
  logic [7:0]            status_q, status_d;
  logic [NUM_TIMERS-1:0] enable_q, enable_d;
  logic [15:0]           tempo_q [NUM_TIMERS];
  logic [15:0]           tempo_d [NUM_TIMERS];
  logic [31:0]           interval_q [NUM_TIMERS];
  logic [31:0]           interval_d [NUM_TIMERS];
  logic [31:0]           count_q [NUM_TIMERS];
  logic [31:0]           count_d [NUM_TIMERS];

  logic        out_valid_q, out_valid_d;
  logic [23:0] out_data_q, out_data_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                  accept;
  logic [32:0]           sum;
  logic                  advance;
  logic [2:0]            tsel;
  logic                  tvalid;
  logic [IdxW-1:0]       tidx;
  logic [15:0]           new_tempo;
  logic [NUM_TIMERS-1:0] new_enable;
  logic [NUM_TIMERS-1:0] rising;

  ectt_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    rd_d        = rd_q;
    status_d    = status_q;
    enable_d    = enable_q;
    tempo_d     = tempo_q;
    interval_d  = interval_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    div_req     = '0;
    advance     = 1'b0;

    sum        = {1'b0, count_q[idx_q]} + {17'b0, cycles_q};
    tsel       = addr_q[3:1];
    tvalid     = addr_q[4] && ({1'b0, tsel} < NumTimersW);
    tidx       = tsel[IdxW-1:0];
    new_tempo  = addr_q[0] ? {tempo_q[tidx][15:8], data_q} : {data_q, tempo_q[tidx][7:0]};
    new_enable = data_q[NUM_TIMERS-1:0];
    rising     = new_enable & ~enable_q;

    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StExec;
        end
      end
      StExec: begin
        rd_d    = 8'h00;
        state_d = StDone;
        case (op_q)
          OpTick: begin
            idx_d   = '0;
            state_d = StTick;
          end
          OpRead: begin
            if (addr_q == AddrStatus) begin
              rd_d = status_q;
            end else if (addr_q == AddrEnable) begin
              rd_d = 8'(enable_q);
            end else if (tvalid) begin
              rd_d = addr_q[0] ? tempo_q[tidx][7:0] : tempo_q[tidx][15:8];
            end
          end
          OpWrite: begin
            if (addr_q == AddrStatus) begin
              status_d = status_q & ~data_q;
            end else if (addr_q == AddrEnable) begin
              for (int i = 0; i < NUM_TIMERS; i++) begin
                if (rising[i]) begin
                  count_d[i] = '0;
                end
              end
              enable_d = new_enable;
            end else if (tvalid) begin
              if (new_tempo == 16'd0) begin
                new_tempo = 16'd1;
              end
              tempo_d[tidx]    = new_tempo;
              idx_d            = tidx;
              div_req.start    = 1'b1;
              div_req.dividend = {1'b0, TicksPerMin};
              div_req.divisor  = {16'b0, new_tempo};
              state_d          = StDiv;
            end
          end
          default: begin
          end
        endcase
      end
      StTick: begin
        if (enable_q[idx_q] && (sum >= {1'b0, interval_q[idx_q]})) begin
          status_d[idx_q]  = 1'b1;
          div_req.start    = 1'b1;
          div_req.dividend = sum;
          div_req.divisor  = interval_q[idx_q];
          state_d          = StMod;
        end else begin
          // A disabled counter sticks at all ones rather than wrapping.
          if (!enable_q[idx_q] && sum[32]) begin
            count_d[idx_q] = '1;
          end else begin
            count_d[idx_q] = sum[31:0];
          end
          advance = 1'b1;
        end
      end
      StMod: begin
        if (div_rsp.done) begin
          count_d[idx_q] = div_rsp.remainder;
          state_d        = StTick;
          advance        = 1'b1;
        end
      end
      StDiv: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient == '0) begin
            interval_d[idx_q] = 32'd1;
          end else begin
            interval_d[idx_q] = div_rsp.quotient[31:0];
          end
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {7'b0, status_q, (status_q != 8'h00), rd_q};
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (advance) begin
      if (idx_q == LastIdx) begin
        state_d = StDone;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      status_q    <= '0;
      enable_q    <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        tempo_q[i]    <= 16'd1;
        interval_q[i] <= TicksPerMin;
        count_q[i]    <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      status_q    <= status_d;
      enable_q    <= enable_d;
      tempo_q     <= tempo_d;
      interval_q  <= interval_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_e'(s_axis_tuser);
      addr_q   <= s_axis_tdata[4:0];
      data_q   <= s_axis_tdata[15:8];
      cycles_q <= s_axis_tdata[31:16];
    end
    rd_q       <= rd_d;
    out_data_q <= out_data_d;
  end

endmodule

`default_nettype wire

// File: rtl/ectt_divider.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The divisor must be nonzero.
module ectt_divider (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  ectt_pkg::div_req_t  req_i,
  output ectt_pkg::div_rsp_t  rsp_o
);
  import ectt_pkg::*;

  localparam int unsigned CntW = $clog2(DividendW + 1);
  localparam logic [CntW-1:0] Steps = CntW'(DividendW);

  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  div_q, div_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  logic [DivisorW:0] trial;
  logic [DivisorW:0] diff;
  logic              fits;

  always_comb begin
    trial  = {rem_q, quo_q[DividendW-1]};
    diff   = trial - {1'b0, div_q};
    fits   = trial >= {1'b0, div_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      div_d  = req_i.divisor;
      cnt_d  = Steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // When the trial fits, the difference is below the divisor and fits its width.
      rem_d = fits ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
      quo_d = {quo_q[DividendW-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

// File: test/eight_channel_tempo_timer_tb.sv
`default_nettype none

module eight_channel_tempo_timer_tb;
  import ectt_pkg::*;

  localparam int unsigned ClockHz    = 8000000;
  localparam int unsigned NumTimers  = 8;
  localparam logic [1:0]  OpUnknown  = 2'd3;
  localparam logic [4:0]  AddrTempoBase = 5'h10;
  localparam logic [7:0]  PresentMask = 8'((1 << NumTimers) - 1);
  localparam int unsigned Chunks     = 8;
  localparam int unsigned ChunkItems = 250;
  localparam int unsigned TailCycles = 300;
  localparam int unsigned MaxPrinted = 30;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  address;
    logic [7:0]  write_data;
    logic [15:0] cycles;
  } timer_cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic [7:0] pending;
  } timer_rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // address, write_data, cycles
  logic [1:0]  s_axis_tuser = '0;   // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // read_data, irq, pending

  eight_channel_tempo_timer #(
    .CLOCK_HZ  (ClockHz),
    .NUM_TIMERS(NumTimers)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Shadow copy of the timer state.
  logic [7:0]  stat_bits;
  logic [7:0]  en_bits;
  logic [15:0] bpm     [NumTimers];
  logic [31:0] period  [NumTimers];
  logic [31:0] elapsed [NumTimers];

  timer_cmd_t cmd_q[$];
  timer_rsp_t rsp_q[$];
  timer_cmd_t cur_cmd;
  timer_rsp_t want_rsp;

  bit          calm;
  int unsigned send_gap;
  int unsigned hold;
  int unsigned n_errors, n_checked, n_ticks, n_reads, n_writes, n_other, n_fires;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] bpm_to_period(input logic [15:0] b);
    longint unsigned q;
    q = (64'd60 * ClockHz) / ((b == 16'd0) ? 64'd1 : {48'd0, b});
    if (q == 0) q = 1;
    if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    return q[31:0];
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [7:0] tempo_addr(input int t, input bit lo);
    return 8'(AddrTempoBase) + 8'(2 * t) + 8'(lo);
  endfunction

  function automatic timer_cmd_t mk_tick(input logic [15:0] c);
    return '{op: OpTick, address: 8'h00, write_data: 8'h00, cycles: c};
  endfunction

  function automatic timer_cmd_t mk_read(input logic [7:0] a);
    return '{op: OpRead, address: a, write_data: 8'h00, cycles: 16'h0000};
  endfunction

  function automatic timer_cmd_t mk_write(input logic [7:0] a, input logic [7:0] d);
    return '{op: OpWrite, address: a, write_data: d, cycles: 16'h0000};
  endfunction

  function automatic timer_cmd_t random_cmd();
    timer_cmd_t  cmd;
    int unsigned r;
    logic [4:0]  a;
    cmd.op         = OpRead;
    cmd.address    = 8'($urandom_range(0, 255));
    cmd.write_data = 8'($urandom_range(0, 255));
    cmd.cycles     = 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 199);
    if (r < 80) begin
      cmd.op = OpTick;
      r = $urandom_range(0, 9);
      if (r == 0) cmd.cycles = 16'($urandom_range(0, 15));
      else if (r == 1) cmd.cycles = 16'hFFFF;
    end else if (r < 120) begin
      cmd.op = OpRead;
    end else if (r < 198) begin
      cmd.op = OpWrite;
      r = $urandom_range(0, 9);
      if (r < 2) a = AddrStatus;
      else if (r < 4) a = AddrEnable;
      else if (r == 4) a = 5'($urandom_range(2, 15));
      else a = AddrTempoBase + 5'($urandom_range(0, 15));
      // High tempo bytes lean toward fast tempos so that the timers fire often.
      if (a >= AddrTempoBase && !a[0]) begin
        r = $urandom_range(0, 19);
        if (r == 0) cmd.write_data = 8'h00;
        else if (r < 14) cmd.write_data = 8'($urandom_range(8'h40, 8'hFF));
      end
      cmd.address[4:0] = a;
    end else begin
      cmd.op = OpUnknown;
    end
    return cmd;
  endfunction

  // Applies one accepted transfer to the shadow state and queues the result it must produce.
  task automatic predict_item(input timer_cmd_t cmd);
    timer_rsp_t  rsp;
    logic [4:0]  a;
    logic [32:0] sum;
    logic [7:0]  enabling;
    int          t;
    rsp = '0;
    a = cmd.address[4:0];
    t = int'(a[3:1]);
    case (cmd.op)
      OpTick: begin
        n_ticks++;
        for (int i = 0; i < NumTimers; i++) begin
          sum = {1'b0, elapsed[i]} + 33'(cmd.cycles);
          if (en_bits[i]) begin
            if (sum >= {1'b0, period[i]}) begin
              sum = sum % {1'b0, period[i]};
              stat_bits[i] = 1'b1;
              n_fires++;
            end
            elapsed[i] = sum[31:0];
          end else begin
            elapsed[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          end
        end
      end
      OpRead: begin
        n_reads++;
        if (a == AddrStatus) rsp.read_data = stat_bits;
        else if (a == AddrEnable) rsp.read_data = en_bits;
        else if (a >= AddrTempoBase && t < NumTimers)
          rsp.read_data = a[0] ? bpm[t][7:0] : bpm[t][15:8];
      end
      OpWrite: begin
        n_writes++;
        if (a == AddrStatus) begin
          stat_bits &= ~cmd.write_data;
        end else if (a == AddrEnable) begin
          enabling = cmd.write_data & PresentMask & ~en_bits;
          for (int i = 0; i < NumTimers; i++) begin
            if (enabling[i]) elapsed[i] = '0;
          end
          en_bits = cmd.write_data & PresentMask;
        end else if (a >= AddrTempoBase && t < NumTimers) begin
          if (a[0]) bpm[t][7:0] = cmd.write_data;
          else bpm[t][15:8] = cmd.write_data;
          if (bpm[t] == 16'd0) bpm[t] = 16'd1;
          period[t] = bpm_to_period(bpm[t]);
        end
      end
      default: begin
        n_other++;
      end
    endcase
    rsp.irq     = |stat_bits;
    rsp.pending = stat_bits;
    rsp_q.push_back(rsp);
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    n_errors++;
    // Printing stops after a while so that a broken block cannot flood the log.
    if (n_errors <= MaxPrinted)
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic wait_drained();
    while (cmd_q.size() != 0 || s_axis_tvalid || rsp_q.size() != 0) @(negedge clk_i);
  endtask

  // Sender side.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_item(cur_cmd);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          cur_cmd = cmd_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cur_cmd.cycles, cur_cmd.write_data, cur_cmd.address};
          s_axis_tuser  <= cur_cmd.op;
          send_gap = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver side: checks every result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (rsp_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", m_axis_tdata, 0);
        end else begin
          want_rsp = rsp_q.pop_front();
          n_checked++;
          if (m_axis_tdata[7:0] != want_rsp.read_data)
            report_mismatch("read_data", m_axis_tdata[7:0], want_rsp.read_data);
          if (m_axis_tdata[8] != want_rsp.irq)
            report_mismatch("irq", m_axis_tdata[8], want_rsp.irq);
          if (m_axis_tdata[16:9] != want_rsp.pending)
            report_mismatch("pending", m_axis_tdata[16:9], want_rsp.pending);
        end
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  initial begin
    stat_bits = '0;
    en_bits   = '0;
    for (int i = 0; i < NumTimers; i++) begin
      bpm[i]     = 16'd1;
      period[i]  = bpm_to_period(16'd1);
      elapsed[i] = '0;
    end
    calm = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    cmd_q.push_back(mk_read(8'(AddrStatus)));
    cmd_q.push_back(mk_read(8'(AddrEnable)));
    cmd_q.push_back(mk_read(tempo_addr(0, 0)));
    cmd_q.push_back(mk_read(tempo_addr(0, 1)));
    // A zero tempo must be stored as one.
    cmd_q.push_back(mk_write(tempo_addr(0, 1), 8'h00));
    cmd_q.push_back(mk_read(tempo_addr(0, 1)));
    cmd_q.push_back(mk_write(tempo_addr(1, 0), 8'hFF));
    cmd_q.push_back(mk_write(tempo_addr(1, 1), 8'hFF));
    cmd_q.push_back(mk_write(8'(AddrEnable), 8'h06));
    cmd_q.push_back(mk_tick(16'hFFFF));
    cmd_q.push_back(mk_tick(16'h0000));
    // Timer 2 now holds a count far above its new interval; the next tick wraps it.
    cmd_q.push_back(mk_write(tempo_addr(2, 0), 8'hFF));
    cmd_q.push_back(mk_tick(16'h0000));
    cmd_q.push_back(mk_read(8'(AddrStatus)));
    cmd_q.push_back(mk_write(8'(AddrStatus), 8'h02));
    cmd_q.push_back(mk_write(8'(AddrStatus), 8'hFF));
    cmd_q.push_back('{op: OpUnknown, address: 8'(AddrEnable), write_data: 8'hFF,
                      cycles: 16'hFFFF});
    cmd_q.push_back(mk_read(8'h05));
    cmd_q.push_back(mk_write(8'h0A, 8'hFF));
    cmd_q.push_back(mk_read({3'b111, AddrEnable}));
    cmd_q.push_back(mk_write(8'(AddrEnable), 8'hFF));
    cmd_q.push_back(mk_tick(16'hFFFF));
    cmd_q.push_back(mk_write(8'(AddrEnable), 8'h00));
    cmd_q.push_back(mk_write(tempo_addr(7, 1) | 8'hE0, 8'h80));
    cmd_q.push_back(mk_read(tempo_addr(7, 1)));

    // Each chunk starts only once the previous one has fully drained.
    for (int c = 0; c < Chunks; c++) begin
      wait_drained();
      calm = (c == 2);
      repeat (ChunkItems) cmd_q.push_back(random_cmd());
    end
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);

    $display("Checked %0d results from %0d ticks, %0d reads, %0d writes and %0d unknown ops.",
             n_checked, n_ticks, n_reads, n_writes, n_other);
    $display("Timers expired %0d times across tempo changes, enables and status clears.",
             n_fires);
    if (n_errors == 0) begin
      $display("eight_channel_tempo_timer verification clean");
    end else begin
      $display("eight_channel_tempo_timer verification failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("eight_channel_tempo_timer verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/ectt_pkg.sv
rtl/ectt_divider.sv
rtl/eight_channel_tempo_timer.sv
test/eight_channel_tempo_timer_tb.sv
